>>> hdl/rtxt_pkg.sv
// Shared definitions for the retransmission table: entry layout, event and
// action codes, sequencer states and default sizes. No dependencies.
package rtxt_pkg;

  // Default number of table entries.
  localparam int DEFAULT_TABLE_DEPTH = 16;

  // Most results that one input transaction produces.
  localparam int RESULT_CAP = 16;
  localparam int RES_W      = $clog2(RESULT_CAP + 1);

  localparam int TIME_W  = 16;
  localparam int ID_W    = 16;
  localparam int RETRY_W = 8;
  localparam int SLOT_W  = 4;
  localparam int KIND_W  = 3;
  localparam int ACT_W   = 2;

  // Input action codes.
  localparam logic [ACT_W-1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACK     = 2'd2;

  // Result event codes.
  localparam logic [KIND_W-1:0] EV_SEND    = 3'd0;
  localparam logic [KIND_W-1:0] EV_EXPIRED = 3'd1;
  localparam logic [KIND_W-1:0] EV_ACKED   = 3'd2;
  localparam logic [KIND_W-1:0] EV_QUEUED  = 3'd3;
  localparam logic [KIND_W-1:0] EV_FULL    = 3'd4;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic               reliable;
    logic [TIME_W-1:0]  interval;
    logic [TIME_W-1:0]  lifetime;
    logic [TIME_W-1:0]  age;
    logic [TIME_W-1:0]  timer;
    logic [RETRY_W-1:0] retry_limit;
    logic [RETRY_W-1:0] retries;
  } entry_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_t;

endpackage

>>> hdl/retransmit_table_with_ack.sv
// Top level of the retransmission table: entry memory, walk sequencer and
// result buffering. Depends on rtxt_pkg.
//
// The table keeps up to TABLE_DEPTH outgoing packet entries in one memory
// with a registered read. A tick or an ack walks the table from slot 0, and
// every visit to a slot reads it, then evaluates and writes it back; a tick
// visits each live entry exactly once, since an entry moved into a freed slot
// comes from the part not yet visited. One result is held back until the
// next one is known, so that the final result of a transaction carries last;
// a stalled output holds the walk at its next result. Each transaction gives
// at most 16 results; further events still update the table.
module retransmit_table_with_ack
  import rtxt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [ACT_W-1:0]   action,
  input  logic [ID_W-1:0]    packet_id,
  input  logic               reliable,
  input  logic [TIME_W-1:0]  retry_interval,
  input  logic [TIME_W-1:0]  lifetime,
  input  logic [RETRY_W-1:0] max_retries,
  input  logic [TIME_W-1:0]  elapsed,
  // Output channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  event_kind,
  output logic [ID_W-1:0]    out_packet_id,
  output logic [SLOT_W-1:0]  slot,
  output logic [RETRY_W-1:0] retries_done,
  output logic               last
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  state_t state, state_next;

  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   last_idx;
  logic [RES_W-1:0]   res_cnt;

  logic [ACT_W-1:0]   op_action;
  logic [ID_W-1:0]    op_pid;
  logic [TIME_W-1:0]  op_elapsed;

  entry_t             mem [TABLE_DEPTH];
  entry_t             rd_cur;
  entry_t             rd_last;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  entry_t             mem_wd;

  logic               pend_valid;
  logic [KIND_W-1:0]  pend_kind;
  logic [ID_W-1:0]    pend_id;
  logic [SLOT_W-1:0]  pend_slot;
  logic [RETRY_W-1:0] pend_retries;

  logic               new_ev;
  logic [KIND_W-1:0]  ev_kind;
  logic [ID_W-1:0]    ev_id;
  logic [SLOT_W-1:0]  ev_slot;
  logic [RETRY_W-1:0] ev_retries;
  logic               emit;
  logic               blocked;
  logic               remove;
  logic               accept;
  logic               out_free;
  logic               push;
  logic               more;
  logic               full;

  logic [TIME_W:0]    age_sum;
  logic [TIME_W:0]    timer_sum;
  logic [TIME_W-1:0]  age_sat;
  logic [TIME_W-1:0]  timer_sat;

  // Handshake terms.
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign more     = ((CNT_W + 1)'(idx) + (CNT_W + 1)'(1)) < (CNT_W + 1)'(count);

  // Saturating timer updates for the entry under evaluation.
  assign age_sum   = {1'b0, rd_cur.age} + {1'b0, op_elapsed};
  assign timer_sum = {1'b0, rd_cur.timer} + {1'b0, op_elapsed};
  assign age_sat   = age_sum[TIME_W] ? {TIME_W{1'b1}} : age_sum[TIME_W-1:0];
  assign timer_sat = timer_sum[TIME_W] ? {TIME_W{1'b1}} : timer_sum[TIME_W-1:0];

  // Entry memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state == S_READ) begin
      rd_cur  <= mem[idx];
      rd_last <= mem[last_idx];
    end
  end

  // Per-state datapath decisions: events, removals and write-back.
  always_comb begin
    new_ev     = 1'b0;
    ev_kind    = EV_SEND;
    ev_id      = rd_cur.id;
    ev_slot    = SLOT_W'(idx);
    ev_retries = rd_cur.retries;
    remove     = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = idx;
    mem_wd     = rd_cur;
    unique case (state)
      S_IDLE: begin
        if (accept && action == ACT_ENQUEUE) begin
          new_ev = 1'b1;
          ev_id  = packet_id;
          if (full) begin
            ev_kind    = EV_FULL;
            ev_slot    = '0;
            ev_retries = '0;
          end else begin
            ev_kind            = EV_QUEUED;
            ev_slot            = SLOT_W'(count);
            ev_retries         = '0;
            mem_we             = 1'b1;
            mem_wa             = IDX_W'(count);
            mem_wd.id          = packet_id;
            mem_wd.reliable    = reliable;
            mem_wd.interval    = retry_interval;
            mem_wd.lifetime    = lifetime;
            mem_wd.age         = '0;
            mem_wd.timer       = '0;
            mem_wd.retry_limit = max_retries;
            mem_wd.retries     = '0;
          end
        end
      end
      S_EVAL: begin
        if (op_action == ACT_TICK) begin
          if (!rd_cur.reliable) begin
            new_ev  = 1'b1;
            ev_kind = EV_SEND;
            remove  = 1'b1;
          end else if (rd_cur.age >= rd_cur.lifetime) begin
            new_ev  = 1'b1;
            ev_kind = EV_EXPIRED;
            remove  = 1'b1;
          end else begin
            mem_we     = 1'b1;
            mem_wd.age = age_sat;
            if (rd_cur.retries < rd_cur.retry_limit) begin
              mem_wd.timer = timer_sat;
              if (timer_sat >= rd_cur.interval) begin
                new_ev         = 1'b1;
                ev_kind        = EV_SEND;
                ev_retries     = rd_cur.retries + RETRY_W'(1);
                mem_wd.retries = ev_retries;
                mem_wd.timer   = '0;
              end
            end
          end
        end else if (rd_cur.id == op_pid) begin
          new_ev  = 1'b1;
          ev_kind = EV_ACKED;
          remove  = 1'b1;
        end
        // A removal fills the hole with the last entry.
        if (remove) begin
          mem_we = 1'b1;
          mem_wd = rd_last;
        end
      end
      default: ;
    endcase
    // The result cap applies to a walk; the count left by the previous walk
    // does not limit the single result of an enqueue.
    emit    = new_ev && ((state == S_IDLE) || (res_cnt < RES_W'(RESULT_CAP)));
    blocked = emit && pend_valid && !out_free;
    if (blocked) begin
      mem_we = 1'b0;
    end
  end

  // The held result moves to the output when a newer one arrives or at the end.
  assign push = pend_valid && out_free &&
                (((state == S_EVAL) && emit) || (state == S_FLUSH));

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((action == ACT_TICK || action == ACT_ACK) && count != '0) begin
            state_next = S_READ;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (!blocked) begin
          if (remove && op_action == ACT_ACK) begin
            state_next = S_FLUSH;
          end else if (more) begin
            state_next = S_READ;
          end else begin
            state_next = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer state, walk index, entry count and result count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      idx     <= '0;
      res_cnt <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        idx     <= '0;
        res_cnt <= emit ? RES_W'(1) : '0;
        if (action == ACT_ENQUEUE && !full) begin
          count <= count + CNT_W'(1);
        end
      end else if (state == S_EVAL && !blocked) begin
        if (emit) begin
          res_cnt <= res_cnt + RES_W'(1);
        end
        if (remove) begin
          count <= count - CNT_W'(1);
        end else if (more) begin
          idx <= idx + IDX_W'(1);
        end
      end
    end
  end

  // Transaction operands kept for the walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_action  <= action;
      op_pid     <= packet_id;
      op_elapsed <= elapsed;
    end
  end

  // Held result, one behind the newest event.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (emit && !blocked) begin
      pend_valid <= 1'b1;
    end else if (push) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && !blocked) begin
      pend_kind    <= ev_kind;
      pend_id      <= ev_id;
      pend_slot    <= ev_slot;
      pend_retries <= ev_retries;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      event_kind    <= pend_kind;
      out_packet_id <= pend_id;
      slot          <= pend_slot;
      retries_done  <= pend_retries;
      last          <= (state == S_FLUSH);
    end
  end

`ifndef SYNTH
  // The table never holds more entries than it has slots.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  // A new transaction is taken only with no result held back.
  assert property (@(posedge clk) disable iff (rst)
    accept |-> !pend_valid)
    else $error("transaction accepted with a pending result");

  // The entry count moves by at most one per cycle.
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CNT_W'(1) ||
                     count + CNT_W'(1) == $past(count)))
    else $error("entry count jumped");

  // No more results are produced than the cap allows.
  assert property (@(posedge clk) disable iff (rst)
    res_cnt <= RES_W'(RESULT_CAP))
    else $error("result count beyond cap");
`endif

endmodule

>>> dv/retransmit_table_with_ack_test.sv
// Self-checking testbench for the retransmission table, built around a queue-fed driver
// and a clocked result monitor. Depends on rtxt_pkg and retransmit_table_with_ack.
`timescale 1ns / 100ps

module retransmit_table_with_ack_test;
  import rtxt_pkg::*;

  localparam int DEPTH = DEFAULT_TABLE_DEPTH;
  localparam int RANDOM_CMDS = 350;
  localparam int HOLD_AFTER = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_PRINTS = 40;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // One command as presented on the input channel.
  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [ID_W-1:0]    id;
    logic               reliable;
    logic [TIME_W-1:0]  interval;
    logic [TIME_W-1:0]  lifetime;
    logic [RETRY_W-1:0] retry_limit;
    logic [TIME_W-1:0]  elapsed;
  } cmd_t;

  // One table event as seen on the output channel.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    id;
    logic [SLOT_W-1:0]  slot;
    logic [RETRY_W-1:0] retries;
    logic               last;
  } ev_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_t drv_cmd = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KIND_W-1:0] event_kind;
  logic [ID_W-1:0] out_packet_id;
  logic [SLOT_W-1:0] slot;
  logic [RETRY_W-1:0] retries_done;
  logic last;

  cmd_t pending_cmds[$];
  ev_t due_events[$];
  entry_t shadow_table[DEPTH];
  int live_entries = 0;
  int cmd_total = 0;
  int accepted_cmds = 0;
  int mismatch_count = 0;

  int tx_gap = 0;
  bit tx_busy = 1'b0;
  int rx_wait = 0;
  bit rx_busy = 1'b1;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int results_taken = 0;

  retransmit_table_with_ack #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(drv_cmd.act),
    .packet_id(drv_cmd.id),
    .reliable(drv_cmd.reliable),
    .retry_interval(drv_cmd.interval),
    .lifetime(drv_cmd.lifetime),
    .max_retries(drv_cmd.retry_limit),
    .elapsed(drv_cmd.elapsed),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .event_kind(event_kind),
    .out_packet_id(out_packet_id),
    .slot(slot),
    .retries_done(retries_done),
    .last(last)
  );

  // Free-running clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic cmd_t mk_cmd(logic [ACT_W-1:0] act, logic [ID_W-1:0] id, logic rel,
                                  logic [TIME_W-1:0] intv, logic [TIME_W-1:0] life,
                                  logic [RETRY_W-1:0] lim, logic [TIME_W-1:0] el);
    mk_cmd = '{act, id, rel, intv, life, lim, el};
  endfunction

  // Mostly small times so that resends and expiries happen, now and then any value.
  function automatic logic [TIME_W-1:0] pick_time(int span);
    if ($urandom_range(0, 9) == 0) return TIME_W'($urandom);
    return TIME_W'($urandom_range(0, span));
  endfunction

  function automatic logic [RETRY_W-1:0] pick_retry_limit();
    if ($urandom_range(0, 9) == 0) return RETRY_W'($urandom);
    return RETRY_W'($urandom_range(0, 4));
  endfunction

  // Idle cycles before the next transaction; zero outside busy stretches.
  function automatic int draw_wait(bit busy);
    if (!busy) return 0;
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 16);
    return $urandom_range(0, 2);
  endfunction

  function automatic logic [TIME_W-1:0] sat_time(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  // Removal fills the hole with the last live entry.
  function automatic void drop_entry(int idx);
    shadow_table[idx] = shadow_table[live_entries - 1];
    live_entries--;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Applies one accepted command to the shadow table and queues the events it causes.
  task automatic predict_table(cmd_t c);
    ev_t evs[$];
    int i;
    case (c.act)
      ACT_ENQUEUE: begin
        if (live_entries >= DEPTH) begin
          evs.push_back('{EV_FULL, c.id, '0, '0, 1'b0});
        end else begin
          shadow_table[live_entries] = '{c.id, c.reliable, c.interval, c.lifetime, '0, '0,
                                         c.retry_limit, '0};
          evs.push_back('{EV_QUEUED, c.id, SLOT_W'(live_entries), '0, 1'b0});
          live_entries++;
        end
      end
      ACT_TICK: begin
        i = 0;
        while (i < live_entries) begin
          if (!shadow_table[i].reliable) begin
            evs.push_back('{EV_SEND, shadow_table[i].id, SLOT_W'(i),
                            shadow_table[i].retries, 1'b0});
            drop_entry(i);
          end else if (shadow_table[i].age >= shadow_table[i].lifetime) begin
            evs.push_back('{EV_EXPIRED, shadow_table[i].id, SLOT_W'(i),
                            shadow_table[i].retries, 1'b0});
            drop_entry(i);
          end else begin
            shadow_table[i].age = sat_time(shadow_table[i].age, c.elapsed);
            if (shadow_table[i].retries < shadow_table[i].retry_limit) begin
              shadow_table[i].timer = sat_time(shadow_table[i].timer, c.elapsed);
              if (shadow_table[i].timer >= shadow_table[i].interval) begin
                shadow_table[i].retries++;
                shadow_table[i].timer = '0;
                evs.push_back('{EV_SEND, shadow_table[i].id, SLOT_W'(i),
                                shadow_table[i].retries, 1'b0});
              end
            end
            i++;
          end
        end
      end
      ACT_ACK: begin
        for (i = 0; i < live_entries; i++) begin
          if (shadow_table[i].id == c.id) begin
            evs.push_back('{EV_ACKED, shadow_table[i].id, SLOT_W'(i),
                            shadow_table[i].retries, 1'b0});
            drop_entry(i);
            break;
          end
        end
      end
      default: ;
    endcase
    // Events past the per-transaction cap still change the table but are not reported.
    while (evs.size() > RESULT_CAP) evs.delete(evs.size() - 1);
    if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[k]) due_events.push_back(evs[k]);
  endtask

  // Driver: presents queued commands with random gaps and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_table(drv_cmd);
        accepted_cmds++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          drv_cmd <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          tx_gap <= draw_wait(tx_busy);
          if ($urandom_range(0, 23) == 0) tx_busy <= ~tx_busy;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls per result, plus one long hold-off to back up the table.
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      results_taken <= 0;
    end else begin
      if (out_valid && !out_stall) results_taken <= results_taken + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait <= rx_wait - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        w = draw_wait(rx_busy);
        rx_wait <= (w > 0) ? w - 1 : 0;
        out_stall <= (w != 0);
        if ($urandom_range(0, 23) == 0) rx_busy <= ~rx_busy;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: every accepted result must match the oldest predicted event.
  always @(posedge clk) begin
    ev_t seen;
    ev_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = '{event_kind, out_packet_id, slot, retries_done, last};
      if (due_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d id %h slot %0d",
                                  seen.kind, seen.id, seen.slot));
      end else begin
        want = due_events.pop_front();
        if (seen.kind != want.kind || seen.id != want.id || seen.slot != want.slot ||
            seen.retries != want.retries || seen.last != want.last) begin
          report_mismatch($sformatf(
            "got kind %0d id %h slot %0d retries %0d last %0b, want %0d %h %0d %0d %0b",
            seen.kind, seen.id, seen.slot, seen.retries, seen.last,
            want.kind, want.id, want.slot, want.retries, want.last));
        end
      end
    end
  end

  // Watchdog for a hung handshake or a missing result.
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    cmd_t c;
    logic [ACT_W-1:0] act;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] recent_ids[$];
    int made;
    int phase_left;
    int mix;
    int r;

    // Directed: empty-table cases and an unused action with every bit set.
    pending_cmds.push_back(mk_cmd(ACT_TICK, 16'h0000, 1'b0, '0, '0, '0, 16'h0007));
    pending_cmds.push_back(mk_cmd(ACT_ACK, 16'h1234, 1'b0, '0, '0, '0, '0));
    pending_cmds.push_back(mk_cmd(ACT_UNUSED, '1, 1'b1, '1, '1, '1, '1));
    // Fill the table: unreliable, zero interval, zero lifetime, no retries allowed.
    for (int k = 0; k < DEPTH; k++) begin
      if (k == 0) begin
        c = mk_cmd(ACT_ENQUEUE, 16'hFFFF, 1'b0, '1, '1, '1, '1);
      end else if (k == 1) begin
        c = mk_cmd(ACT_ENQUEUE, 16'h0000, 1'b1, 16'd0, 16'hFFFF, 8'hFF, '0);
      end else if (k == 2) begin
        c = mk_cmd(ACT_ENQUEUE, 16'h00A5, 1'b1, 16'd5, 16'd0, 8'd3, '0);
      end else if (k == 3) begin
        c = mk_cmd(ACT_ENQUEUE, 16'h5A5A, 1'b1, 16'd0, 16'hFFFF, 8'd0, '0);
      end else begin
        c = mk_cmd(ACT_ENQUEUE, ID_W'(16'h1000 + k), 1'b1, TIME_W'(k), 16'h8000, 8'd2, '0);
      end
      pending_cmds.push_back(c);
    end
    pending_cmds.push_back(mk_cmd(ACT_ENQUEUE, 16'hBEEF, 1'b1, 16'd1, 16'd1, 8'd1, '0));
    // Max-elapsed tick, a hit and a miss on ack, then a tick that expires everything.
    pending_cmds.push_back(mk_cmd(ACT_TICK, '0, 1'b0, '0, '0, '0, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(ACT_ACK, 16'h0000, 1'b0, '0, '0, '0, '0));
    pending_cmds.push_back(mk_cmd(ACT_ACK, 16'h1234, 1'b0, '0, '0, '0, '0));
    pending_cmds.push_back(mk_cmd(ACT_TICK, '0, 1'b0, '0, '0, '0, 16'h0000));
    pending_cmds.push_back(mk_cmd(ACT_TICK, '0, 1'b0, '0, '0, '0, 16'h0003));

    // Random: stretches that favor filling, draining or a mix; acks mostly use recent ids.
    made = 0;
    phase_left = 0;
    mix = 0;
    while (made < RANDOM_CMDS) begin
      if (phase_left == 0) begin
        mix = $urandom_range(0, 2);
        phase_left = $urandom_range(10, 30);
      end
      phase_left--;
      r = $urandom_range(0, 99);
      case (mix)
        0: act = (r < 65) ? ACT_ENQUEUE : (r < 85) ? ACT_TICK : ACT_ACK;
        1: act = (r < 20) ? ACT_ENQUEUE : (r < 65) ? ACT_TICK : ACT_ACK;
        default: act = (r < 40) ? ACT_ENQUEUE : (r < 75) ? ACT_TICK : ACT_ACK;
      endcase
      if ($urandom_range(0, 49) == 0) act = ACT_UNUSED;
      if (act == ACT_ACK && recent_ids.size() != 0 && $urandom_range(0, 3) != 0) begin
        id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
      end else if ($urandom_range(0, 9) < 7) begin
        id = ID_W'($urandom_range(0, 15));
      end else begin
        id = ID_W'($urandom);
      end
      if (act == ACT_ENQUEUE) begin
        recent_ids.push_back(id);
        if (recent_ids.size() > 24) void'(recent_ids.pop_front());
      end
      pending_cmds.push_back(mk_cmd(act, id, ($urandom_range(0, 4) != 0), pick_time(12),
                                    pick_time(80), pick_retry_limit(), pick_time(10)));
      if (act != ACT_UNUSED) made++;
    end
    cmd_total = pending_cmds.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to be taken and every predicted event to come back.
    while (accepted_cmds < cmd_total) @(negedge clk);
    while (due_events.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
